// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the stamp spacer.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/bss_pkg.sv -----
// Shared types, codes and width helpers of the brush stroke stamp spacer.
// No dependencies.
package bss_pkg;

    localparam int MAX_STAMPS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int CARRY_W        = 26;
    localparam int SPACING_W      = 16;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_DRAG    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [2:0] MUL_XX = 3'd0;
    localparam logic [2:0] MUL_YY = 3'd1;
    localparam logic [2:0] MUL_SX = 3'd2;
    localparam logic [2:0] MUL_SY = 3'd3;
    localparam logic [2:0] MUL_DX = 3'd4;
    localparam logic [2:0] MUL_DY = 3'd5;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int seg_bits(input int c, input int f);
        return c + f + 1;
    endfunction

    function automatic int div_bits(input int c, input int f);
        return max2(CARRY_W, c + seg_bits(c, f) + 2);
    endfunction

    typedef struct packed {
        logic       take;
        logic       press_out;
        logic       mul_en;
        logic [2:0] mul_op;
        logic       acc_add;
        logic       sq_start;
        logic       sq_step;
        logic       seg_done;
        logic       div_start;
        logic       div_coord;
        logic       div_step;
        logic       due_done;
        logic       x_done;
        logic       y_done;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic seg_zero;
        logic due_zero;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// ----- hw/rtl/brush_stroke_stamp_spacer.sv -----
// Flow: a press stamp passes from S_PRESS into the output register once it is free; a drag's
// first stamp follows square root and carry division, one bit a cycle, then both
// coordinate divisions. Each further stamp waits for the two coordinate divisions on
// the one shared divider; one event at a time.
// Reset: rst_n clears stroke, carry and spacing (to 1) at once; no clearing pass.
module brush_stroke_stamp_spacer #(
    parameter int MAX_STAMPS = bss_pkg::MAX_STAMPS_DEF,
    parameter int COORD_BITS = bss_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bss_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,  // pos_x, pos_y
    input  logic [1:0]                          s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,  // stamp_x, stamp_y
    output logic                                m_tlast,  // last_stamp
    output logic                                m_tuser,  // stamps_dropped
    input  logic                                cfg_we,
    input  logic [bss_pkg::SPACING_W-1:0]       cfg_wdata
);

    localparam int TD_W = ((2 * COORD_BITS + 7) / 8) * 8;

    bss_pkg::cmd_t                cmd;
    bss_pkg::sts_t                sts;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;

    bss_ctrl #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bss_dp #(
        .MAX_STAMPS (MAX_STAMPS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_op       (s_tuser),
        .in_x        (s_tdata[COORD_BITS-1:0]),
        .in_y        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_last    (m_tlast),
        .out_dropped (m_tuser)
    );

    assign m_tdata = TD_W'({out_y, out_x});

endmodule

// ----- hw/rtl/bss_ctrl.sv -----
// Sequencer of the stamp spacer: steps square root, divisions and stamp emission.
// Depends on bss_pkg.
module bss_ctrl #(
    parameter int COORD_BITS = bss_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bss_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_op,
    output logic             in_ready,
    input  bss_pkg::sts_t    sts,
    output bss_pkg::cmd_t    cmd
);

    localparam int SEG_W = bss_pkg::seg_bits(COORD_BITS, FRAC_BITS);
    localparam int DW    = bss_pkg::div_bits(COORD_BITS, FRAC_BITS);
    localparam int CNT_W = $clog2(bss_pkg::max2(SEG_W, DW) + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PRESS = 5'd1;
    localparam logic [4:0] S_MXX   = 5'd2;
    localparam logic [4:0] S_MYY   = 5'd3;
    localparam logic [4:0] S_SQI   = 5'd4;
    localparam logic [4:0] S_SQ    = 5'd5;
    localparam logic [4:0] S_SEG   = 5'd6;
    localparam logic [4:0] S_DVI   = 5'd7;
    localparam logic [4:0] S_DV    = 5'd8;
    localparam logic [4:0] S_DUE   = 5'd9;
    localparam logic [4:0] S_MSX   = 5'd10;
    localparam logic [4:0] S_MDX   = 5'd11;
    localparam logic [4:0] S_DXI   = 5'd12;
    localparam logic [4:0] S_DXS   = 5'd13;
    localparam logic [4:0] S_XEND  = 5'd14;
    localparam logic [4:0] S_MSY   = 5'd15;
    localparam logic [4:0] S_MDY   = 5'd16;
    localparam logic [4:0] S_DYI   = 5'd17;
    localparam logic [4:0] S_DYS   = 5'd18;
    localparam logic [4:0] S_YEND  = 5'd19;
    localparam logic [4:0] S_EMIT  = 5'd20;

    logic [4:0]       state_reg;
    logic [4:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_op == bss_pkg::OP_PRESS)
                    begin
                        state_next = S_PRESS;
                    end
                    else if (in_op == bss_pkg::OP_DRAG && sts.active)
                    begin
                        state_next = S_MXX;
                    end
                end
            end
            S_PRESS:
            begin
                if (sts.out_free)
                begin
                    cmd.press_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MXX:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = bss_pkg::MUL_XX;
                state_next = S_MYY;
            end
            S_MYY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = bss_pkg::MUL_YY;
                cmd.acc_add = 1'b1;
                state_next  = S_SQI;
            end
            S_SQI:
            begin
                cmd.sq_start = 1'b1;
                cnt_next     = '0;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SEG_W - 1))
                begin
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                cmd.seg_done = 1'b1;
                state_next   = sts.seg_zero ? S_IDLE : S_DVI;
            end
            S_DVI:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_DV;
            end
            S_DV, S_DXS, S_DYS:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    state_next = (state_reg == S_DV)  ? S_DUE :
                                 (state_reg == S_DXS) ? S_XEND : S_YEND;
                end
            end
            S_DUE:
            begin
                cmd.due_done = 1'b1;
                state_next   = sts.due_zero ? S_IDLE : S_MSX;
            end
            S_MSX:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = bss_pkg::MUL_SX;
                state_next = S_MDX;
            end
            S_MDX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = bss_pkg::MUL_DX;
                cmd.acc_add = 1'b1;
                state_next  = S_DXI;
            end
            S_DXI:
            begin
                cmd.div_start = 1'b1;
                cmd.div_coord = 1'b1;
                cnt_next      = '0;
                state_next    = S_DXS;
            end
            S_XEND:
            begin
                cmd.x_done = 1'b1;
                state_next = S_MSY;
            end
            S_MSY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = bss_pkg::MUL_SY;
                state_next = S_MDY;
            end
            S_MDY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = bss_pkg::MUL_DY;
                cmd.acc_add = 1'b1;
                state_next  = S_DYI;
            end
            S_DYI:
            begin
                cmd.div_start = 1'b1;
                cmd.div_coord = 1'b1;
                cnt_next      = '0;
                state_next    = S_DYS;
            end
            S_YEND:
            begin
                cmd.y_done = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last ? S_IDLE : S_MSX;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/bss_dp.sv -----
// Datapath of the stamp spacer: stroke state, shared multiplier, square root,
// divider and the output register. Depends on bss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bss_dp #(
    parameter int MAX_STAMPS = bss_pkg::MAX_STAMPS_DEF,
    parameter int COORD_BITS = bss_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bss_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          in_op,
    input  logic signed [COORD_BITS-1:0]        in_x,
    input  logic signed [COORD_BITS-1:0]        in_y,
    input  logic                                cfg_we,
    input  logic [bss_pkg::SPACING_W-1:0]       cfg_wdata,
    input  bss_pkg::cmd_t                       cmd,
    output bss_pkg::sts_t                       sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        out_x,
    output logic signed [COORD_BITS-1:0]        out_y,
    output logic                                out_last,
    output logic                                out_dropped
);

    localparam int C      = COORD_BITS;
    localparam int SEG_W  = bss_pkg::seg_bits(COORD_BITS, FRAC_BITS);
    localparam int DW     = bss_pkg::div_bits(COORD_BITS, FRAC_BITS);
    localparam int SP_W   = bss_pkg::SPACING_W + FRAC_BITS;
    localparam int DV_W   = bss_pkg::max2(SP_W, SEG_W + 1);
    localparam int TR_W   = bss_pkg::max2(bss_pkg::max2(SEG_W, SP_W), bss_pkg::CARRY_W) + 2;
    localparam int MA     = C + 1;
    localparam int ACC_W  = MA + TR_W + 1;
    localparam int SQ_W   = 2 * SEG_W;
    localparam int RW     = SEG_W + 2;
    localparam int EMIT_W = $clog2(MAX_STAMPS + 1);
    localparam int CW     = bss_pkg::CARRY_W;

    logic [bss_pkg::SPACING_W-1:0] spacing_reg;
    logic                          active_reg;
    logic signed [C-1:0]           prev_x_reg;
    logic signed [C-1:0]           prev_y_reg;
    logic [CW-1:0]                 carried_reg;
    logic signed [C:0]             dx_reg;
    logic signed [C:0]             dy_reg;
    logic signed [C-1:0]           sx_reg;
    logic signed [C-1:0]           sy_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [SQ_W-1:0]               sq_op_reg;
    logic [RW-1:0]                 sq_rem_reg;
    logic [SEG_W-1:0]              sq_root_reg;
    logic [SEG_W-1:0]              seg_reg;
    logic [CW-1:0]                 carry_reg;
    logic [DW-1:0]                 quo_reg;
    logic [DV_W-1:0]               rem_reg;
    logic [DV_W-1:0]               den_reg;
    logic                          neg_reg;
    logic [EMIT_W-1:0]             emit_reg;
    logic [EMIT_W-1:0]             idx_reg;
    logic                          dropped_reg;
    logic signed [TR_W-1:0]        travel_reg;
    logic signed [C-1:0]           rx_reg;
    logic signed [C-1:0]           ry_reg;
    logic                          out_valid_reg;
    logic signed [C-1:0]           out_x_reg;
    logic signed [C-1:0]           out_y_reg;
    logic                          out_last_reg;
    logic                          out_dropped_reg;

    logic [SP_W-1:0]               sp;
    logic signed [C:0]             ux;
    logic signed [C:0]             uy;
    logic signed [MA-1:0]          a_m;
    logic signed [TR_W-1:0]        b_m;
    logic signed [MA+TR_W-1:0]     prod;
    logic signed [ACC_W-1:0]       acc_next;
    logic [RW+1:0]                 sq_t;
    logic [RW+1:0]                 sq_trial;
    logic [DV_W:0]                 dv_t;
    logic                          dv_ge;
    logic signed [ACC_W-1:0]       mag;
    logic [C-1:0]                  q_c;
    logic signed [C-1:0]           coord_res;
    logic                          out_free;

    assign sp = {(spacing_reg == '0) ? bss_pkg::SPACING_W'(1) : spacing_reg,
                 {FRAC_BITS{1'b0}}};
    assign ux = dx_reg[C] ? -dx_reg : dx_reg;
    assign uy = dy_reg[C] ? -dy_reg : dy_reg;

    always_comb
    begin
        case (cmd.mul_op)
            bss_pkg::MUL_XX:
            begin
                a_m = ux;
                b_m = TR_W'(ux);
            end
            bss_pkg::MUL_YY:
            begin
                a_m = uy;
                b_m = TR_W'(uy);
            end
            bss_pkg::MUL_SX:
            begin
                a_m = MA'(sx_reg);
                b_m = signed'(TR_W'(seg_reg));
            end
            bss_pkg::MUL_SY:
            begin
                a_m = MA'(sy_reg);
                b_m = signed'(TR_W'(seg_reg));
            end
            bss_pkg::MUL_DX:
            begin
                a_m = dx_reg;
                b_m = travel_reg;
            end
            bss_pkg::MUL_DY:
            begin
                a_m = dy_reg;
                b_m = travel_reg;
            end
            default:
            begin
                a_m = '0;
                b_m = '0;
            end
        endcase
    end

    assign prod     = a_m * b_m;
    assign acc_next = cmd.acc_add ? acc_reg + ACC_W'(prod) : ACC_W'(prod);

    assign sq_t     = {sq_rem_reg, sq_op_reg[SQ_W-1 -: 2]};
    assign sq_trial = (RW + 2)'({sq_root_reg, 2'b01});

    assign dv_t  = {rem_reg, quo_reg[DW-1]};
    assign dv_ge = (dv_t >= {1'b0, den_reg});

    assign mag       = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign q_c       = quo_reg[C-1:0];
    assign coord_res = neg_reg ? -signed'(q_c) : signed'(q_c);

    assign out_free = !out_valid_reg || out_ready;

    assign sts.active   = active_reg;
    assign sts.seg_zero = (sq_root_reg == '0);
    assign sts.due_zero = (quo_reg == '0);
    assign sts.last     = ((idx_reg + EMIT_W'(1)) == emit_reg);
    assign sts.out_free = out_free;

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= bss_pkg::SPACING_W'(1);
            active_reg    <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            carried_reg   <= '0;
            emit_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                spacing_reg <= cfg_wdata;
            end
            if (cmd.take)
            begin
                if (in_op == bss_pkg::OP_PRESS)
                begin
                    active_reg  <= 1'b1;
                    prev_x_reg  <= in_x;
                    prev_y_reg  <= in_y;
                    carried_reg <= '0;
                end
                else if (in_op == bss_pkg::OP_RELEASE)
                begin
                    active_reg  <= 1'b0;
                    carried_reg <= '0;
                end
                else if (in_op == bss_pkg::OP_DRAG && active_reg)
                begin
                    prev_x_reg <= in_x;
                    prev_y_reg <= in_y;
                end
            end
            if (cmd.due_done)
            begin
                carried_reg <= CW'(rem_reg);
                emit_reg    <= (quo_reg > DW'(MAX_STAMPS)) ? EMIT_W'(MAX_STAMPS)
                                                           : quo_reg[EMIT_W-1:0];
                dropped_reg <= (quo_reg > DW'(MAX_STAMPS));
            end
            if (cmd.press_out || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            dx_reg <= (C + 1)'(in_x) - (C + 1)'(prev_x_reg);
            dy_reg <= (C + 1)'(in_y) - (C + 1)'(prev_y_reg);
            sx_reg <= prev_x_reg;
            sy_reg <= prev_y_reg;
        end
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.sq_start)
        begin
            sq_op_reg   <= {{(SQ_W - 2 * C - 1){1'b0}}, acc_reg[2*C:0]} << (2 * FRAC_BITS);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_op_reg <= sq_op_reg << 2;
            if (sq_t >= sq_trial)
            begin
                sq_rem_reg  <= RW'(sq_t - sq_trial);
                sq_root_reg <= {sq_root_reg[SEG_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_t[RW-1:0];
                sq_root_reg <= {sq_root_reg[SEG_W-2:0], 1'b0};
            end
        end
        if (cmd.seg_done)
        begin
            seg_reg   <= sq_root_reg;
            carry_reg <= CW'(CW'(sq_root_reg) + carried_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            if (cmd.div_coord)
            begin
                quo_reg <= DW'({mag, 1'b0}) + DW'(seg_reg);
                den_reg <= DV_W'({seg_reg, 1'b0});
                neg_reg <= acc_reg[ACC_W-1];
            end
            else
            begin
                quo_reg <= DW'(carry_reg);
                den_reg <= DV_W'(sp);
                neg_reg <= 1'b0;
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= dv_ge ? DV_W'(dv_t - {1'b0, den_reg}) : dv_t[DV_W-1:0];
            quo_reg <= {quo_reg[DW-2:0], dv_ge};
        end
        if (cmd.due_done)
        begin
            idx_reg    <= '0;
            travel_reg <= signed'(TR_W'(seg_reg)) - signed'(TR_W'(carry_reg))
                          + signed'(TR_W'(sp));
        end
        if (cmd.x_done)
        begin
            rx_reg <= coord_res;
        end
        if (cmd.y_done)
        begin
            ry_reg <= coord_res;
        end
        if (cmd.press_out)
        begin
            out_x_reg       <= prev_x_reg;
            out_y_reg       <= prev_y_reg;
            out_last_reg    <= 1'b1;
            out_dropped_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_x_reg       <= rx_reg;
            out_y_reg       <= ry_reg;
            out_last_reg    <= sts.last;
            out_dropped_reg <= dropped_reg;
            idx_reg         <= idx_reg + EMIT_W'(1);
            travel_reg      <= travel_reg + signed'(TR_W'(sp));
        end
    end

    `ASSERT_ALWAYS(a_emit_max, emit_reg <= EMIT_W'(MAX_STAMPS), "stamp count above limit")
    `ASSERT_ALWAYS(a_drop_full, !dropped_reg || emit_reg == EMIT_W'(MAX_STAMPS),
        "drop flagged without a full run")
    `ASSERT_ALWAYS(a_load_free, !(cmd.emit || cmd.press_out) || out_free,
        "output loaded while occupied")
    `ASSERT_NEXT(a_carry_rem, cmd.due_done, CW'(carried_reg) < CW'(sp),
        "carry not below spacing")

endmodule

// ----- tb/brush_stroke_stamp_spacer_test.sv -----
// Self-checking testbench of brush_stroke_stamp_spacer: drives press, drag and release
// transfers, predicts the stamps in its own model and compares every output transfer.
// Depends on bss_pkg and the brush_stroke_stamp_spacer RTL.
`timescale 1ns / 1ps

module brush_stroke_stamp_spacer_test;

    localparam int  MAXST    = 64;
    localparam int  WDOG_LIM = 4000;
    localparam int  SETTLE   = 200;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint unsigned CMASK = (64'd1 << bss_pkg::CARRY_W) - 1;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               dropped;
    } stamp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = bss_pkg::OP_PRESS;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // model state
    logic [15:0]        spacing;
    logic               in_stroke;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    longint unsigned    carry_len;

    stamp_t stamps_due[$];
    bit     failed = 1'b0;
    bit     quiet = 1'b0;
    int     stall_left = 0;
    int     idle_cnt = 0;

    brush_stroke_stamp_spacer dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    task automatic predict_stamps(input logic [1:0] op, input logic signed [15:0] px,
                                  input logic signed [15:0] py);
        longint          dx, dy, len, trav, sx, sy;
        longint unsigned ux, uy, seg, sp, carry, due, emit, ci;
        stamp_t          s;
        if (op == bss_pkg::OP_PRESS)
        begin
            in_stroke = 1'b1;
            last_x = px;
            last_y = py;
            carry_len = 0;
            s.x = px; s.y = py; s.last = 1'b1; s.dropped = 1'b0;
            stamps_due.push_back(s);
        end
        else if (op == bss_pkg::OP_RELEASE)
        begin
            in_stroke = 1'b0;
            carry_len = 0;
        end
        else if (op == bss_pkg::OP_DRAG && in_stroke)
        begin
            sx = last_x;
            sy = last_y;
            dx = longint'(px) - sx;
            dy = longint'(py) - sy;
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            seg = int_sqrt((ux * ux + uy * uy) << 16);
            sp = longint'(spacing == 0 ? 16'd1 : spacing) << 8;
            last_x = px;
            last_y = py;
            if (seg != 0)
            begin
                carry = (carry_len + seg) & CMASK;
                due = carry / sp;
                emit = due > MAXST ? MAXST : due;
                len = seg;
                for (longint unsigned i = 0; i < emit; i++)
                begin
                    ci = carry - i * sp;
                    trav = longint'(seg - (ci - sp));
                    s.x = 16'(round_div(sx * len + dx * trav, len));
                    s.y = 16'(round_div(sy * len + dy * trav, len));
                    s.last = (i + 1 == emit);
                    s.dropped = (due > MAXST);
                    stamps_due.push_back(s);
                end
                carry_len = (carry - due * sp) & CMASK;
            end
        end
    endtask

    task automatic send_event(input logic [1:0] op, input logic signed [15:0] px,
                              input logic signed [15:0] py);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_stamps(op, px, py);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (stamps_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_spacing(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        spacing = v;
    endtask

    // receive, check, watchdog and output back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (stamps_due.size() == 0)
                begin
                    $error("unexpected stamp x=%0d y=%0d", $signed(m_tdata[15:0]),
                           $signed(m_tdata[31:16]));
                    failed = 1'b1;
                end
                else
                begin
                    stamp_t e;
                    e = stamps_due.pop_front();
                    if (m_tdata[15:0] !== e.x)
                    begin
                        $error("stamp_x expected %0d actual %0d", e.x, $signed(m_tdata[15:0]));
                        failed = 1'b1;
                    end
                    if (m_tdata[31:16] !== e.y)
                    begin
                        $error("stamp_y expected %0d actual %0d", e.y, $signed(m_tdata[31:16]));
                        failed = 1'b1;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last_stamp expected %0d actual %0d", e.last, m_tlast);
                        failed = 1'b1;
                    end
                    if (m_tuser !== e.dropped)
                    begin
                        $error("stamps_dropped expected %0d actual %0d", e.dropped, m_tuser);
                        failed = 1'b1;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_LIM)
            begin
                $display("Regression FAIL");
                $finish;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_press_extremes;
        send_event(bss_pkg::OP_PRESS, 16'sh7FFF, -16'sh8000);
        send_event(bss_pkg::OP_PRESS, -16'sh8000, 16'sh7FFF);
        send_event(bss_pkg::OP_PRESS, 16'sh0000, 16'sh0000);
        send_event(bss_pkg::OP_PRESS, -16'sh0001, -16'sh0001);
    endtask

    task automatic test_drag_cases;
        send_event(bss_pkg::OP_DRAG, 16'sd5, 16'sd5);         // drag on from the last press
        send_event(bss_pkg::OP_PRESS, 16'sd0, 16'sd0);
        send_event(bss_pkg::OP_DRAG, 16'sd3, 16'sd4);
        send_event(bss_pkg::OP_DRAG, 16'sd3, 16'sd4);         // zero-length segment
        send_event(bss_pkg::OP_DRAG, -16'sd7, 16'sd2);
        send_event(bss_pkg::OP_PRESS, 16'sd10, 16'sd10);      // restart mid-stroke
        send_event(bss_pkg::OP_DRAG, 16'sd13, 16'sd6);
        send_event(OP_UNUSED, 16'sd40, 16'sd40);
        send_event(bss_pkg::OP_DRAG, 16'sd13, 16'sd200);      // more than the stamp limit
        send_event(bss_pkg::OP_DRAG, 16'sh7FFF, 16'sh7FFF);
        send_event(bss_pkg::OP_DRAG, -16'sh8000, -16'sh8000);
        send_event(bss_pkg::OP_RELEASE, 16'sh7FFF, -16'sh8000);
        send_event(bss_pkg::OP_DRAG, 16'sd0, 16'sd0);
    endtask

    task automatic test_spacing_extremes;
        set_spacing(16'hFFFF);
        send_event(bss_pkg::OP_PRESS, -16'sh8000, -16'sh8000);
        send_event(bss_pkg::OP_DRAG, 16'sh7FFF, 16'sh7FFF);
        send_event(bss_pkg::OP_DRAG, -16'sh8000, 16'sh7FFF);
        send_event(bss_pkg::OP_RELEASE, 16'sd0, 16'sd0);
        set_spacing(16'h0000);
        send_event(bss_pkg::OP_PRESS, 16'sd1, 16'sd1);
        send_event(bss_pkg::OP_DRAG, 16'sd4, -16'sd3);
        send_event(bss_pkg::OP_RELEASE, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_strokes(input int n_items);
        int                 sent;
        int                 span;
        logic [15:0]        sp_pick;
        logic signed [15:0] nx, ny;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent % 50 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: sp_pick = 16'd1;
                    1: sp_pick = 16'd3;
                    2: sp_pick = 16'hFFFF;
                    3: sp_pick = 16'($urandom_range(1, 40));
                    default: sp_pick = 16'($urandom);
                endcase
                set_spacing(sp_pick);
            end
            if ($urandom_range(0, 9) < 8)
            begin
                span = (spacing == 0 ? 1 : spacing) * 3;
                if (span > 30000 || span < 4)
                    span = span < 4 ? 8 : 30000;
                if (spacing == 1 && $urandom_range(0, 3) != 0)
                    span = 20;
                send_event(bss_pkg::OP_PRESS, 16'($urandom), 16'($urandom));
                sent++;
                repeat ($urandom_range(1, 6))
                begin
                    nx = last_x + 16'($signed($urandom_range(0, 2 * span)) - span);
                    ny = last_y + 16'($signed($urandom_range(0, 2 * span)) - span);
                    send_event(bss_pkg::OP_DRAG, nx, ny);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    send_event(bss_pkg::OP_RELEASE, 16'($urandom), 16'($urandom));
                    sent++;
                end
            end
            else
            begin
                send_event(2'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        spacing = 16'd1;
        in_stroke = 1'b0;
        last_x = '0;
        last_y = '0;
        carry_len = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_press_extremes();
        test_drag_cases();
        test_spacing_extremes();
        test_random_strokes(170);
        drain();
        quiet = 1'b1;
        test_random_strokes(30);
        drain();
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
